// File: design/hmtp_pkg.sv
// shared types, constants and character codes for the height map text parser
package hmtp_pkg;

    localparam int CHAR_W      = 8;
    localparam int OUT_COORD_W = 12;
    localparam int DATA_W      = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int COORD_BITS_DEFAULT = 12;

    // register word index taken from paddr[2]
    localparam logic REG_DEFAULT_COLOR = 1'b0;

    localparam logic [DATA_W-1:0] DEFAULT_COLOR_RESET = 32'h00FF_FFFF;

    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LC_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UC_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UC_Z    = 8'h5A;

    typedef struct packed {
        logic       is_dec;
        logic       is_sign;
        logic       is_minus;
        logic       is_comma;
        logic       is_newline;
        logic       is_alnum;
        logic       is_x;
        logic       is_zero;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

endpackage

// File: design/hmtp_if.sv
// item channels: map text bytes in, vertices out

interface hmtp_char_if;
    logic                           valid;
    logic                           ready;
    logic [hmtp_pkg::CHAR_W-1:0]    ch;
    logic                           last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hmtp_vertex_if;
    logic                               valid;
    logic                               ready;
    logic [hmtp_pkg::OUT_COORD_W-1:0]   row;
    logic [hmtp_pkg::OUT_COORD_W-1:0]   col;
    logic signed [hmtp_pkg::DATA_W-1:0] height;
    logic [hmtp_pkg::DATA_W-1:0]        color;

    modport source (output valid, output row, output col, output height, output color,
                    input ready);
    modport sink   (input valid, input row, input col, input height, input color,
                    output ready);
endinterface

// File: design/hmtp_classify.sv
// character classifier: decimal, sign, hex, alphanumeric, x, zero and separator flags plus digit value
module hmtp_classify
(
    input  logic [hmtp_pkg::CHAR_W-1:0] ch,
    output hmtp_pkg::char_class_t       cls
);

    logic is_lower;
    logic is_upper;
    logic is_lc_hex;
    logic is_uc_hex;
    logic [hmtp_pkg::CHAR_W-1:0] offs;

    always_comb
    begin
        is_lower  = (ch >= hmtp_pkg::CH_LC_A) && (ch <= hmtp_pkg::CH_LC_Z);
        is_upper  = (ch >= hmtp_pkg::CH_UC_A) && (ch <= hmtp_pkg::CH_UC_Z);
        is_lc_hex = (ch >= hmtp_pkg::CH_LC_A) && (ch <= hmtp_pkg::CH_LC_F);
        is_uc_hex = (ch >= hmtp_pkg::CH_UC_A) && (ch <= hmtp_pkg::CH_UC_F);

        cls.is_dec     = (ch >= hmtp_pkg::CH_0) && (ch <= hmtp_pkg::CH_9);
        cls.is_minus   = (ch == hmtp_pkg::CH_MINUS);
        cls.is_sign    = (ch == hmtp_pkg::CH_PLUS) || cls.is_minus;
        cls.is_comma   = (ch == hmtp_pkg::CH_COMMA);
        cls.is_newline = (ch == hmtp_pkg::CH_NEWLINE);
        cls.is_alnum   = cls.is_dec || is_lower || is_upper;
        cls.is_x       = (ch == hmtp_pkg::CH_LC_X) || (ch == hmtp_pkg::CH_UC_X);
        cls.is_zero    = (ch == hmtp_pkg::CH_0);
        cls.is_hex     = cls.is_dec || is_lc_hex || is_uc_hex;

        // hex letters map to 10..15 from their offset past 'a' or 'A'
        if (is_lc_hex)
        begin
            offs = ch - hmtp_pkg::CH_LC_A + 8'd10;
        end
        else if (is_uc_hex)
        begin
            offs = ch - hmtp_pkg::CH_UC_A + 8'd10;
        end
        else
        begin
            offs = ch - hmtp_pkg::CH_0;
        end
        cls.digit = offs[3:0];
    end

endmodule

// File: design/height_map_text_parser.sv
// top level: height map text parser with apb config register
//
// Parses map text one byte per item. Each token (optional sign, decimal
// height, optional ",0x" hex colour) yields one vertex with its row, column,
// height and colour; tokens without a colour take default_color (apb offset
// 0x0, reset 0x00FFFFFF). Throughput is one byte per cycle while the output is
// not stalled: each byte goes from an input register through the classifier
// and parser state update into the vertex register, and one more byte is
// taken while a finished vertex waits. The byte that ends a token passes the
// input register, then its vertex is registered in the vertex register. The
// byte marked last flushes a pending token and returns the parser to row 1,
// column 1; row and column stop at 2^COORD_BITS-1 and show their low 12 bits.
module height_map_text_parser
#(
    parameter int COORD_BITS = hmtp_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    hmtp_char_if.sink                         char_in,
    hmtp_vertex_if.source                     vertex_out,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hmtp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hmtp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hmtp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HACC   = 3'd1;
    localparam logic [2:0] PH_HSKIP  = 3'd2;
    localparam logic [2:0] PH_CSTART = 3'd3;
    localparam logic [2:0] PH_CZERO  = 3'd4;
    localparam logic [2:0] PH_CHEX   = 3'd5;
    localparam logic [2:0] PH_ASKIP  = 3'd6;

    localparam int DW = hmtp_pkg::DATA_W;
    localparam int OW = hmtp_pkg::OUT_COORD_W;
    localparam int EXT_W = (COORD_BITS > OW) ? COORD_BITS : OW;
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // config register
    logic [DW-1:0] default_color_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hmtp_pkg::REG_DEFAULT_COLOR);
    assign prdata = (paddr[2] == hmtp_pkg::REG_DEFAULT_COLOR) ? default_color_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= hmtp_pkg::DEFAULT_COLOR_RESET;
        end
        else if (cfg_wr)
        begin
            default_color_reg <= pwdata;
        end
    end

    // input register
    logic                        in_valid_reg;
    logic [hmtp_pkg::CHAR_W-1:0] ch_reg;
    logic                        last_reg;
    logic                        advance;
    logic                        in_take;

    assign advance       = in_valid_reg && (!vertex_out.valid || vertex_out.ready);
    assign char_in.ready = !in_valid_reg || advance;
    assign in_take       = char_in.valid && char_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg   <= char_in.ch;
            last_reg <= char_in.last;
        end
    end

    hmtp_pkg::char_class_t cls;

    hmtp_classify u_classify
    (
        .ch  (ch_reg),
        .cls (cls)
    );

    // parser state
    logic [2:0]            phase_reg,       phase_next;
    logic [COORD_BITS-1:0] row_reg,         row_next;
    logic [COORD_BITS-1:0] col_reg,         col_next;
    logic [DW-1:0]         height_acc_reg,  height_acc_next;
    logic                  negative_reg,    negative_next;
    logic [DW-1:0]         color_acc_reg,   color_acc_next;
    logic                  color_given_reg, color_given_next;

    logic                  emit;
    logic [COORD_BITS-1:0] e_row;
    logic [COORD_BITS-1:0] e_col;
    logic [DW-1:0]         e_height;
    logic [DW-1:0]         e_color;
    logic                  end_token;

    always_comb
    begin
        phase_next       = phase_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        height_acc_next  = height_acc_reg;
        negative_next    = negative_reg;
        color_acc_next   = color_acc_reg;
        color_given_next = color_given_reg;
        end_token        = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (cls.is_dec || cls.is_sign)
                begin
                    phase_next       = PH_HACC;
                    negative_next    = cls.is_minus;
                    height_acc_next  = cls.is_dec ? DW'(cls.digit) : '0;
                    color_acc_next   = '0;
                    color_given_next = 1'b0;
                end
            end
            PH_HACC, PH_HSKIP:
            begin
                if (cls.is_dec && (phase_reg == PH_HACC))
                begin
                    height_acc_next = (height_acc_reg << 3) + (height_acc_reg << 1)
                                    + DW'(cls.digit);
                end
                else if (cls.is_dec || cls.is_sign)
                begin
                    phase_next = PH_HSKIP;
                end
                else if (cls.is_comma)
                begin
                    phase_next       = PH_CSTART;
                    color_given_next = 1'b1;
                    color_acc_next   = '0;
                end
                else if (cls.is_alnum)
                begin
                    phase_next = PH_ASKIP;
                end
                else
                begin
                    end_token = 1'b1;
                end
            end
            default:
            begin
                if (!cls.is_alnum)
                begin
                    end_token = 1'b1;
                end
                else if (phase_reg == PH_ASKIP)
                begin
                    phase_next = PH_ASKIP;
                end
                else if ((phase_reg == PH_CZERO) && cls.is_x)
                begin
                    phase_next = PH_CHEX;
                end
                else if (cls.is_hex)
                begin
                    color_acc_next = {color_acc_reg[DW-5:0], cls.digit};
                    phase_next = ((phase_reg == PH_CSTART) && cls.is_zero) ? PH_CZERO
                                                                           : PH_CHEX;
                end
                else
                begin
                    phase_next = PH_ASKIP;
                end
            end
        endcase

        // vertex is taken from the state after this byte's token update, before the column and row advance
        emit     = end_token || (last_reg && (phase_next != PH_IDLE));
        e_row    = row_next;
        e_col    = col_next;
        e_height = negative_next ? (DW'(0) - height_acc_next) : height_acc_next;
        e_color  = color_given_next ? color_acc_next : default_color_reg;

        if (end_token)
        begin
            phase_next = PH_IDLE;
            if (col_next != COORD_MAX)
            begin
                col_next = col_next + COORD_ONE;
            end
        end

        // newline outside a token or ending one
        if (cls.is_newline && ((phase_reg == PH_IDLE) || end_token))
        begin
            if (row_next != COORD_MAX)
            begin
                row_next = row_next + COORD_ONE;
            end
            col_next = COORD_ONE;
        end

        if (last_reg)
        begin
            phase_next       = PH_IDLE;
            row_next         = COORD_ONE;
            col_next         = COORD_ONE;
            height_acc_next  = '0;
            negative_next    = 1'b0;
            color_acc_next   = '0;
            color_given_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            row_reg         <= COORD_ONE;
            col_reg         <= COORD_ONE;
            height_acc_reg  <= '0;
            negative_reg    <= 1'b0;
            color_acc_reg   <= '0;
            color_given_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            height_acc_reg  <= height_acc_next;
            negative_reg    <= negative_next;
            color_acc_reg   <= color_acc_next;
            color_given_reg <= color_given_next;
        end
    end

    // vertex register
    logic                 out_valid_reg;
    logic [OW-1:0]        out_row_reg;
    logic [OW-1:0]        out_col_reg;
    logic [DW-1:0]        out_height_reg;
    logic [DW-1:0]        out_color_reg;
    logic [EXT_W-1:0]     e_row_ext;
    logic [EXT_W-1:0]     e_col_ext;

    assign e_row_ext = EXT_W'(e_row);
    assign e_col_ext = EXT_W'(e_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (vertex_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_row_reg    <= e_row_ext[OW-1:0];
            out_col_reg    <= e_col_ext[OW-1:0];
            out_height_reg <= e_height;
            out_color_reg  <= e_color;
        end
    end

    assign vertex_out.valid  = out_valid_reg;
    assign vertex_out.row    = out_row_reg;
    assign vertex_out.col    = out_col_reg;
    assign vertex_out.height = out_height_reg;
    assign vertex_out.color  = out_color_reg;

endmodule

// File: design/hmtp_checker.sv
// port-level checks for the height map text parser, bound to the top level
module hmtp_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [hmtp_pkg::OUT_COORD_W-1:0]  out_row,
    input  logic [hmtp_pkg::OUT_COORD_W-1:0]  out_col,
    input  logic [hmtp_pkg::DATA_W-1:0]       out_height,
    input  logic [hmtp_pkg::DATA_W-1:0]       out_color,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hmtp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hmtp_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [hmtp_pkg::APB_DATA_W-1:0]   prdata
);

    // a stalled vertex stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(out_height) && $stable(out_color))
        else $error("vertex changed while stalled");

    // input only backs up when the vertex register is blocked
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // coordinates start at 1
    a_coord_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_col != '0))
        else $error("vertex with zero row or column");

    // written colour reads back
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == hmtp_pkg::REG_DEFAULT_COLOR)
        |=> (paddr[2] != hmtp_pkg::REG_DEFAULT_COLOR) || (prdata == $past(pwdata)))
        else $error("default colour readback mismatch");

endmodule

bind height_map_text_parser hmtp_checker u_hmtp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (char_in.ready),
    .out_valid  (vertex_out.valid),
    .out_ready  (vertex_out.ready),
    .out_row    (vertex_out.row),
    .out_col    (vertex_out.col),
    .out_height (vertex_out.height),
    .out_color  (vertex_out.color),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

// File: test/height_map_text_parser_test.sv
// testbench for the height map text parser: directed and random text against a local parser
module height_map_text_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W      = hmtp_pkg::CHAR_W;
    localparam int OUT_COORD_W = hmtp_pkg::OUT_COORD_W;
    localparam int DATA_W      = hmtp_pkg::DATA_W;
    localparam int APB_ADDR_W  = hmtp_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = hmtp_pkg::APB_DATA_W;

    localparam logic [CHAR_W-1:0] CH_0       = hmtp_pkg::CH_0;
    localparam logic [CHAR_W-1:0] CH_9       = hmtp_pkg::CH_9;
    localparam logic [CHAR_W-1:0] CH_PLUS    = hmtp_pkg::CH_PLUS;
    localparam logic [CHAR_W-1:0] CH_MINUS   = hmtp_pkg::CH_MINUS;
    localparam logic [CHAR_W-1:0] CH_COMMA   = hmtp_pkg::CH_COMMA;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = hmtp_pkg::CH_NEWLINE;
    localparam logic [CHAR_W-1:0] CH_LC_A    = hmtp_pkg::CH_LC_A;
    localparam logic [CHAR_W-1:0] CH_LC_F    = hmtp_pkg::CH_LC_F;
    localparam logic [CHAR_W-1:0] CH_LC_X    = hmtp_pkg::CH_LC_X;
    localparam logic [CHAR_W-1:0] CH_LC_Z    = hmtp_pkg::CH_LC_Z;
    localparam logic [CHAR_W-1:0] CH_UC_A    = hmtp_pkg::CH_UC_A;
    localparam logic [CHAR_W-1:0] CH_UC_F    = hmtp_pkg::CH_UC_F;
    localparam logic [CHAR_W-1:0] CH_UC_X    = hmtp_pkg::CH_UC_X;
    localparam logic [CHAR_W-1:0] CH_UC_Z    = hmtp_pkg::CH_UC_Z;
    localparam logic [DATA_W-1:0] DEFAULT_COLOR_RESET = hmtp_pkg::DEFAULT_COLOR_RESET;

    localparam int COORD_BITS = hmtp_pkg::COORD_BITS_DEFAULT;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [APB_ADDR_W-1:0] ADDR_DEFAULT_COLOR = {hmtp_pkg::REG_DEFAULT_COLOR, 2'b00};
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 1500;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ALL_ONES = 8'hFF;

    typedef enum logic [2:0]
    {
        SCAN_IDLE,
        SCAN_HEIGHT,
        SCAN_HEIGHT_SKIP,
        SCAN_COLOR_START,
        SCAN_COLOR_ZERO,
        SCAN_COLOR_HEX,
        SCAN_WORD_SKIP
    } scan_phase_e;

    typedef enum int
    {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BLOCKED
    } rx_pattern_e;

    typedef struct packed
    {
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic [DATA_W-1:0]      height;
        logic [DATA_W-1:0]      color;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    hmtp_char_if   char_bus();
    hmtp_vertex_if vertex_bus();

    height_map_text_parser #(.COORD_BITS(COORD_BITS)) DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_bus),
        .vertex_out (vertex_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // parser state as the block should hold it
    scan_phase_e             scan_phase = SCAN_IDLE;
    logic [COORD_BITS-1:0]   row_pos = 1;
    logic [COORD_BITS-1:0]   col_pos = 1;
    logic [DATA_W-1:0]       height_acc = '0;
    logic                    height_neg = 1'b0;
    logic [DATA_W-1:0]       color_acc = '0;
    logic                    color_seen = 1'b0;
    logic [DATA_W-1:0]       default_color = DEFAULT_COLOR_RESET;

    vertex_t expected_vertices[$];

    int errors = 0;
    int bytes_sent = 0;
    int vertices_seen = 0;
    int texts_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return is_digit(c) || (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic int hex_value(input logic [CHAR_W-1:0] c);
        if (is_digit(c))
            return int'(c - CH_0);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic void next_row();
        if (row_pos != COORD_MAX)
            row_pos++;
        col_pos = 1;
    endfunction

    function automatic void emit_vertex();
        vertex_t v;
        v.row    = OUT_COORD_W'(row_pos);
        v.col    = OUT_COORD_W'(col_pos);
        v.height = height_neg ? -height_acc : height_acc;
        v.color  = color_seen ? color_acc : default_color;
        expected_vertices.push_back(v);
        if (col_pos != COORD_MAX)
            col_pos++;
        scan_phase = SCAN_IDLE;
    endfunction

    function automatic void advance_parser(input logic [CHAR_W-1:0] c, input logic mark_last);
        logic emitted;
        int   nibble;
        emitted = 1'b0;
        nibble = hex_value(c);
        case (scan_phase)
            SCAN_IDLE:
            begin
                if (is_digit(c) || is_sign(c))
                begin
                    scan_phase = SCAN_HEIGHT;
                    height_neg = (c == CH_MINUS);
                    height_acc = is_digit(c) ? DATA_W'(c - CH_0) : '0;
                    color_acc = '0;
                    color_seen = 1'b0;
                end
                else if (c == CH_NEWLINE)
                    next_row();
            end
            SCAN_HEIGHT, SCAN_HEIGHT_SKIP:
            begin
                if (is_digit(c) && scan_phase == SCAN_HEIGHT)
                    height_acc = height_acc * 10 + DATA_W'(c - CH_0);
                else if (is_digit(c) || is_sign(c))
                    scan_phase = SCAN_HEIGHT_SKIP;
                else if (c == CH_COMMA)
                begin
                    scan_phase = SCAN_COLOR_START;
                    color_seen = 1'b1;
                    color_acc = '0;
                end
                else if (is_alnum(c))
                    scan_phase = SCAN_WORD_SKIP;
                else
                begin
                    emit_vertex();
                    emitted = 1'b1;
                    if (c == CH_NEWLINE)
                        next_row();
                end
            end
            default:
            begin
                if (!is_alnum(c))
                begin
                    emit_vertex();
                    emitted = 1'b1;
                    if (c == CH_NEWLINE)
                        next_row();
                end
                else if (scan_phase == SCAN_COLOR_ZERO && (c == CH_LC_X || c == CH_UC_X))
                    scan_phase = SCAN_COLOR_HEX;
                else if (scan_phase != SCAN_WORD_SKIP)
                begin
                    if (nibble >= 0)
                    begin
                        color_acc = {color_acc[DATA_W-5:0], 4'(nibble)};
                        scan_phase = (scan_phase == SCAN_COLOR_START && c == CH_0) ?
                                     SCAN_COLOR_ZERO : SCAN_COLOR_HEX;
                    end
                    else
                        scan_phase = SCAN_WORD_SKIP;
                end
            end
        endcase

        // the final byte flushes a pending token and rewinds to row 1, column 1
        if (mark_last)
        begin
            if (scan_phase != SCAN_IDLE && !emitted)
                emit_vertex();
            scan_phase = SCAN_IDLE;
            row_pos = 1;
            col_pos = 1;
            height_acc = '0;
            height_neg = 1'b0;
            color_acc = '0;
            color_seen = 1'b0;
        end
    endfunction

    function automatic void report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                            input logic [DATA_W-1:0] got);
        errors++;
        $display("%0t: vertex %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    task automatic check_vertex();
        vertex_t want;
        vertices_seen++;
        if (expected_vertices.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected vertex, expected none, got row %0d col %0d height %0d",
                     $time, vertex_bus.row, vertex_bus.col, vertex_bus.height);
            $display("%0t: unexpected vertex color %0h", $time, vertex_bus.color);
        end
        else
        begin
            want = expected_vertices.pop_front();
            if (vertex_bus.row !== want.row)
                report_mismatch("row", DATA_W'(want.row), DATA_W'(vertex_bus.row));
            if (vertex_bus.col !== want.col)
                report_mismatch("col", DATA_W'(want.col), DATA_W'(vertex_bus.col));
            if (vertex_bus.height !== want.height)
                report_mismatch("height", want.height, vertex_bus.height);
            if (vertex_bus.color !== want.color)
                report_mismatch("color", want.color, vertex_bus.color);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && vertex_bus.valid && vertex_bus.ready)
            check_vertex();
    end

    // receiver stalls: switches between open, random, sparse and blocked ready patterns
    initial
    begin
        rx_pattern_e pattern;
        int span;
        vertex_bus.ready = 1'b0;
        forever
        begin
            pattern = rx_pattern_e'($urandom_range(0, 3));
            span = $urandom_range(8, 80);
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (pattern)
                    RX_OPEN:   vertex_bus.ready = 1'b1;
                    RX_RANDOM: vertex_bus.ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: vertex_bus.ready = (i % 4 == 3);
                    default:   vertex_bus.ready = (i >= span / 2);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("height_map_text_parser_test NOT OK");
        $finish;
    end

    // sender works in bursts; valid stays high across back-to-back items
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic mark_last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 8))
                begin
                    @(negedge clk);
                    char_bus.valid = 1'b0;
                end
        end
        burst_left--;
        @(negedge clk);
        char_bus.valid = 1'b1;
        char_bus.ch = c;
        char_bus.last = mark_last;
        do
            @(posedge clk);
        while (char_bus.ready !== 1'b1);
        bytes_sent++;
        advance_parser(c, mark_last);
    endtask

    task automatic send_string(input string s, input logic mark_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], mark_last && i == s.len() - 1);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        char_bus.valid = 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        // a last item with no vertex may still be in flight
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_default_color(input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_DEFAULT_COLOR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        default_color = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== value)
        begin
            errors++;
            $display("%0t: default_color readback mismatch, expected %0h, got %0h",
                     $time, value, prdata);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_directed_tokens();
        send_string("7,0X1F\n", 1'b0);
        // empty colour ended by a high byte
        send_string("-0,", 1'b0);
        send_char(CH_ALL_ONES, 1'b0);
        // sign after sign, then a zero byte as separator
        send_string("+-5", 1'b0);
        send_char(CH_NUL, 1'b0);
        // x after two zeros stops the colour
        send_string("9,00x1 ", 1'b0);
        send_string("8zq", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_height_wrap();
        send_string("2147483647\n2147483648 -2147483648 -2147483649\n", 1'b0);
        send_string("4294967297,0xABCDEF012 99999999999,0XcafeBABE -", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_last_byte();
        send_string("5", 1'b1);
        send_string("6\n", 1'b1);
        send_string(" ", 1'b1);
        send_string("\n\n3,f", 1'b1);
        wait_until_drained();
    endtask

    task automatic test_random_text();
        logic [DATA_W-1:0]  settings[5];
        logic [CHAR_W-1:0]  text[$];
        logic [CHAR_W-1:0]  sep;
        logic               signed_tok;
        int                 target;
        int                 digits;
        int                 nibble;
        settings = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, DEFAULT_COLOR_RESET, $urandom};
        foreach (settings[k])
        begin
            wait_until_drained();
            set_default_color(settings[k]);
            target = bytes_sent + RANDOM_ITEMS / 5;
            while (bytes_sent < target)
            begin
                text.delete();
                repeat ($urandom_range(1, 25))
                begin
                    if ($urandom_range(0, 6) == 0)
                        text.push_back(CHAR_W'($urandom_range(0, 255)));
                    else
                    begin
                        signed_tok = ($urandom_range(0, 3) == 0);
                        if (signed_tok)
                            text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) :
                                 $urandom_range(signed_tok ? 0 : 1, 4);
                        repeat (digits)
                            text.push_back(CH_0 + CHAR_W'($urandom_range(0, 9)));
                        if ($urandom_range(0, 9) == 0)
                            text.push_back($urandom_range(0, 1) ? CH_MINUS :
                                           CH_0 + CHAR_W'($urandom_range(0, 9)));
                        if ($urandom_range(0, 11) == 0)
                            text.push_back(CH_LC_A + CHAR_W'($urandom_range(0, 25)));
                        if ($urandom_range(0, 1) == 0)
                        begin
                            text.push_back(CH_COMMA);
                            if ($urandom_range(0, 2) != 0)
                            begin
                                text.push_back(CH_0);
                                text.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                            end
                            repeat ($urandom_range(0, 9))
                            begin
                                nibble = $urandom_range(0, 15);
                                if (nibble < 10)
                                    text.push_back(CH_0 + CHAR_W'(nibble));
                                else
                                    text.push_back(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) +
                                                   CHAR_W'(nibble - 10));
                            end
                            // letter past f, x among them
                            if ($urandom_range(0, 9) == 0)
                                text.push_back(CH_LC_A + CHAR_W'($urandom_range(6, 25)));
                        end
                        case ($urandom_range(0, 6))
                            0: sep = CH_NEWLINE;
                            1: sep = CH_NUL;
                            2: sep = CH_ALL_ONES;
                            3: sep = CH_TAB;
                            4:
                            begin
                                do
                                    sep = CHAR_W'($urandom_range(0, 255));
                                while (is_alnum(sep) || is_sign(sep) || sep == CH_COMMA);
                            end
                            default: sep = CH_SPACE;
                        endcase
                        text.push_back(sep);
                    end
                end
                // often leave a token open so the last byte has to flush it
                if (text.size() > 1 && $urandom_range(0, 2) == 0)
                    void'(text.pop_back());
                foreach (text[i])
                    send_char(text[i], i == text.size() - 1);
                texts_sent++;
                if ($urandom_range(0, 19) == 0)
                    wait_until_drained();
            end
        end
        wait_until_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        char_bus.valid = 1'b0;
        char_bus.ch = '0;
        char_bus.last = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_tokens();
        test_height_wrap();
        test_last_byte();
        test_random_text();

        $display("covered %0d bytes incl. %0d random texts with stalls, %0d vertices",
                 bytes_sent, texts_sent, vertices_seen);
        $display("default color: reset value, zero, all ones and random values");
        if (errors == 0 && expected_vertices.size() == 0)
            $display("height_map_text_parser_test OK");
        else
            $display("height_map_text_parser_test NOT OK");
        $finish;
    end

endmodule

// File: sim.f
design/hmtp_pkg.sv
design/hmtp_if.sv
design/hmtp_classify.sv
design/height_map_text_parser.sv
design/hmtp_checker.sv
test/height_map_text_parser_test.sv
